// ----- rtl/hcbd_pkg.sv -----
`default_nettype none

package hcbd_pkg;

    // One input item: a body byte or an end-of-input marker.
    typedef struct packed {
        logic       kind;
        logic [7:0] byte_in;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] payload;
        logic       chunk_end;
        logic [1:0] status;
    } result_t;

    // Classified item, front to back.
    typedef struct packed {
        logic       is_end;
        logic       is_cr;
        logic       is_lf;
        logic       is_hex;
        logic       is_space;
        logic [3:0] hex_val;
        logic [7:0] data;
    } token_t;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_END  = 1'b1;

    localparam logic [1:0] OUT_PAYLOAD  = 2'd0;
    localparam logic [1:0] OUT_TERMINAL = 2'd1;
    localparam logic [1:0] OUT_STATUS   = 2'd2;

    localparam logic [1:0] ST_COMPLETE  = 2'd0;
    localparam logic [1:0] ST_CUT_SIZE  = 2'd1;
    localparam logic [1:0] ST_CUT_DATA  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LFF   = 8'h66;

    // Depth of the result queue; two entries keep one item per cycle flowing while results are popped.
    localparam int RESULT_DEPTH = 2;

endpackage

`default_nettype wire

// ----- rtl/http_chunked_body_decoder_core.sv -----
`default_nettype none

// Chunked HTTP body decoder. Body bytes (kind 0) and end-of-input markers
// (kind 1) are pushed in; payload bytes, a terminal-chunk marker and an
// end-of-input status come out of a result queue. The block takes one item
// per clock, sustained, as long as results are popped: the back end updates
// its decoder state for each item it pops, and that update sets the rate.
// The result of an accepted item is registered in the item queue (after the
// classifier) and then in the result queue (after the decoder) before it
// shows on the result ports and can be popped. Size lines skip leading
// whitespace, accumulate hex digits into SIZE_BITS bits and close on any
// other byte; only CR directly followed by LF ends a line. A size that
// would exceed SIZE_BITS bits sends the decoder, once its line ends, into
// an error state that swallows bytes until end of input reports status 3.
// Bytes after the terminal chunk are dropped. QUEUE_DEPTH (at least 2)
// sizes the item queue between the classifier and the decoder.
module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS   = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire hcbd_pkg::item_t   item,
    output logic                   empty,
    input  wire logic              pop,
    output hcbd_pkg::result_t      result
);

    localparam int TW = $bits(hcbd_pkg::token_t);
    localparam int RW = $bits(hcbd_pkg::result_t);

    hcbd_pkg::token_t  tok_in;
    hcbd_pkg::token_t  tok_out;
    logic [TW-1:0]     tok_rd;
    logic              tok_empty;
    logic              tok_pop;

    hcbd_pkg::result_t res;
    logic [RW-1:0]     res_rd;
    logic              res_push;
    logic              res_full;

    // front: classify each item as it is taken
    hcbd_front u_front (
        .item  (item),
        .token (tok_in)
    );

    // item queue between classifier and decoder
    hcbd_queue #(
        .WIDTH (TW),
        .DEPTH (QUEUE_DEPTH)
    ) u_tok_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (tok_in),
        .full    (full),
        .rd_en   (tok_pop),
        .rd_data (tok_rd),
        .empty   (tok_empty)
    );

    assign tok_out = tok_rd;

    // back: chunk decoder state machine
    hcbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok_out),
        .tok_empty (tok_empty),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue; decouples the decoder from a stalled consumer
    hcbd_queue #(
        .WIDTH (RW),
        .DEPTH (hcbd_pkg::RESULT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign result = res_rd;

endmodule

`default_nettype wire

// ----- rtl/hcbd_queue.sv -----
`default_nettype none

module hcbd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hcbd_front.sv -----
`default_nettype none

module hcbd_front (
    input  wire hcbd_pkg::item_t item,
    output hcbd_pkg::token_t     token
);

    logic [7:0] b;
    logic       is_dig, is_up, is_low;

    assign b      = item.byte_in;
    assign is_dig = (b >= hcbd_pkg::CH_0)  && (b <= hcbd_pkg::CH_9);
    assign is_up  = (b >= hcbd_pkg::CH_UA) && (b <= hcbd_pkg::CH_UF);
    assign is_low = (b >= hcbd_pkg::CH_LA) && (b <= hcbd_pkg::CH_LFF);

    always_comb
    begin
        token.is_end   = (item.kind == hcbd_pkg::KIND_END);
        token.is_cr    = (b == hcbd_pkg::CH_CR);
        token.is_lf    = (b == hcbd_pkg::CH_LF);
        token.is_hex   = is_dig || is_up || is_low;
        // space, and tab through CR
        token.is_space = (b == hcbd_pkg::CH_SPACE)
                      || ((b >= hcbd_pkg::CH_TAB) && (b <= hcbd_pkg::CH_CR));
        token.data     = b;
        priority if (is_dig)
        begin
            token.hex_val = b[3:0];
        end
        else if (is_up || is_low)
        begin
            token.hex_val = b[3:0] + 4'd9;   // 'A'/'a' low nibble is 1
        end
        else
        begin
            token.hex_val = 4'd0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hcbd_back.sv -----
`default_nettype none

module hcbd_back #(
    parameter int SIZE_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hcbd_pkg::token_t tok,
    input  wire logic             tok_empty,
    output logic                  tok_pop,
    input  wire logic             res_full,
    output logic                  res_push,
    output hcbd_pkg::result_t     res
);

    localparam logic [2:0] PH_SIZE     = 3'd0;
    localparam logic [2:0] PH_DATA     = 3'd1;
    localparam logic [2:0] PH_AFTER_CR = 3'd2;
    localparam logic [2:0] PH_AFTER_LF = 3'd3;
    localparam logic [2:0] PH_DONE     = 3'd4;
    localparam logic [2:0] PH_ERROR    = 3'd5;

    logic [2:0]           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] size_acc_reg, size_acc_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic                 seen_reg, seen_next;
    logic                 closed_reg, closed_next;
    logic                 prev_cr_reg, prev_cr_next;
    logic                 size_ovf_reg, size_ovf_next;

    // size-line step results
    logic                 eff_prev_cr;
    logic [2:0]           sl_phase;
    logic [SIZE_BITS-1:0] sl_acc, sl_left;
    logic                 sl_seen, sl_closed, sl_prev, sl_ovf, sl_term;

    assign tok_pop = !tok_empty && !res_full;

    // A CR that went unmatched after chunk data counts as the previous byte.
    assign eff_prev_cr = (phase_reg == PH_AFTER_LF) ? 1'b1 : prev_cr_reg;

    always_comb
    begin
        sl_phase  = PH_SIZE;
        sl_acc    = size_acc_reg;
        sl_left   = bytes_left_reg;
        sl_seen   = seen_reg;
        sl_closed = closed_reg;
        sl_prev   = tok.is_cr;
        sl_ovf    = size_ovf_reg;
        sl_term   = 1'b0;
        if (eff_prev_cr && tok.is_lf)
        begin
            sl_prev   = 1'b0;
            sl_acc    = '0;
            sl_seen   = 1'b0;
            sl_closed = 1'b0;
            priority if (size_ovf_reg)
            begin
                sl_phase = PH_ERROR;
            end
            else if (size_acc_reg == '0)
            begin
                sl_phase = PH_DONE;
                sl_term  = 1'b1;
            end
            else
            begin
                sl_phase = PH_DATA;
                sl_left  = size_acc_reg;
            end
        end
        else if (!closed_reg)
        begin
            if (tok.is_hex)
            begin
                sl_seen = 1'b1;
                if (!size_ovf_reg)
                begin
                    if (size_acc_reg[SIZE_BITS-1 -: 4] != 4'd0)
                    begin
                        sl_ovf = 1'b1;
                    end
                    else
                    begin
                        sl_acc = {size_acc_reg[SIZE_BITS-5:0], tok.hex_val};
                    end
                end
            end
            else if (seen_reg || !tok.is_space)
            begin
                sl_closed = 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        size_acc_next   = size_acc_reg;
        bytes_left_next = bytes_left_reg;
        seen_next       = seen_reg;
        closed_next     = closed_reg;
        prev_cr_next    = prev_cr_reg;
        size_ovf_next   = size_ovf_reg;
        res_push        = 1'b0;
        res             = '0;
        if (tok_pop)
        begin
            if (tok.is_end)
            begin
                res_push     = 1'b1;
                res.out_kind = hcbd_pkg::OUT_STATUS;
                unique case (phase_reg)
                    PH_DONE:  res.status = hcbd_pkg::ST_COMPLETE;
                    PH_DATA:  res.status = hcbd_pkg::ST_CUT_DATA;
                    PH_ERROR: res.status = hcbd_pkg::ST_OVERFLOW;
                    default:  res.status = hcbd_pkg::ST_CUT_SIZE;
                endcase
                phase_next      = PH_SIZE;
                size_acc_next   = '0;
                bytes_left_next = '0;
                seen_next       = 1'b0;
                closed_next     = 1'b0;
                prev_cr_next    = 1'b0;
                size_ovf_next   = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_DATA:
                    begin
                        bytes_left_next = bytes_left_reg - 1'b1;
                        res_push        = 1'b1;
                        res.out_kind    = hcbd_pkg::OUT_PAYLOAD;
                        res.payload     = tok.data;
                        if (bytes_left_reg == SIZE_BITS'(1))
                        begin
                            res.chunk_end = 1'b1;
                            phase_next    = PH_AFTER_CR;
                        end
                    end
                    PH_AFTER_CR, PH_AFTER_LF, PH_SIZE:
                    begin
                        if (phase_reg == PH_AFTER_CR && tok.is_cr)
                        begin
                            phase_next = PH_AFTER_LF;
                        end
                        else if (phase_reg == PH_AFTER_LF && tok.is_lf)
                        begin
                            phase_next = PH_SIZE;
                        end
                        else
                        begin
                            phase_next      = sl_phase;
                            size_acc_next   = sl_acc;
                            bytes_left_next = sl_left;
                            seen_next       = sl_seen;
                            closed_next     = sl_closed;
                            prev_cr_next    = sl_prev;
                            size_ovf_next   = sl_ovf;
                            if (sl_term)
                            begin
                                res_push     = 1'b1;
                                res.out_kind = hcbd_pkg::OUT_TERMINAL;
                            end
                        end
                    end
                    default:
                    begin
                        // done or error: bytes dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            size_acc_reg   <= '0;
            bytes_left_reg <= '0;
            seen_reg       <= 1'b0;
            closed_reg     <= 1'b0;
            prev_cr_reg    <= 1'b0;
            size_ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            size_acc_reg   <= size_acc_next;
            bytes_left_reg <= bytes_left_next;
            seen_reg       <= seen_next;
            closed_reg     <= closed_next;
            prev_cr_reg    <= prev_cr_next;
            size_ovf_reg   <= size_ovf_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_data_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("data phase with no bytes left");

    a_chunk_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res.chunk_end |-> phase_reg == PH_DATA
                                      && bytes_left_reg == SIZE_BITS'(1))
        else $error("chunk_end not on last byte");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into full queue");

    a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        tok_pop && tok.is_end |=> phase_reg == PH_SIZE && size_acc_reg == '0
                                  && !size_ovf_reg && !closed_reg)
        else $error("end item did not rearm");

    a_ovf_phase: assert property (@(posedge clk) disable iff (!rst_n)
        size_ovf_reg |-> phase_reg == PH_SIZE || phase_reg == PH_ERROR)
        else $error("overflow flag outside size line");
`endif

endmodule

`default_nettype wire
